// ===== hdl/bcpg_pkg.sv =====
// Package for the Bezier curve point generator.
// Holds the controller/datapath command and status types and the fixed sizes.
// No dependencies.
package bcpg_pkg;

	localparam int COORD_W  = 16;
	localparam int OUT_W    = 24;
	localparam int IDX_W    = 6;
	localparam int WGT_W    = 20;
	localparam int DEN_W    = 18;
	localparam int ACC_W    = 37;
	localparam int NPTS     = 4;
	localparam int DIV_BITS = 24;
	localparam int DCNT_W   = $clog2(DIV_BITS);

	typedef struct packed {
		logic             load;
		logic             wgt1;
		logic             wgt2;
		logic             mac;
		logic [1:0]       mac_k;
		logic             div_init;
		logic             div_step;
		logic             emit;
	} bcpg_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last_pt;
		logic out_free;
	} bcpg_stat_t;

endpackage

// ===== hdl/bezier_curve_point_generator.sv =====
// Top level of the Bezier curve point generator.
// Joins bcpg_ctrl and bcpg_datapath; uses bcpg_pkg.
//
// Usage: one input item (mode, steps N, four control points) is taken on the
// in_valid/in_ready channel. The block then delivers N+1 result items on the
// out_valid/out_ready channel, the point at t = i/N for i = 0 to N, with
// last set on the final one. An item with N equal to zero yields no result.
// Output coordinates are signed with 8 fraction bits, rounded to nearest, ties up.
//
// Sequence: every point runs the Bernstein weights (WGT1, WGT2), one
// multiply-accumulate step per control point (MAC), the divider load that
// forms the dividend (DIVI), the radix-2 restoring dividers that run x and y
// side by side (DIV), and the load of the output register (EMIT).
//
// The output register decouples the sides: the next point is computed while
// a finished one waits. When the receiver stalls, the block holds in its emit
// step until the register frees. A new item is taken once the last point of
// the previous one is in the output register. Reset returns the controller to
// idle and empties the output register.
module bezier_curve_point_generator import bcpg_pkg::*; #(
	parameter int MAX_STEPS = 63
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [IDX_W-1:0]          steps,
	input  logic signed [COORD_W-1:0] p0_x,
	input  logic signed [COORD_W-1:0] p0_y,
	input  logic signed [COORD_W-1:0] p1_x,
	input  logic signed [COORD_W-1:0] p1_y,
	input  logic signed [COORD_W-1:0] p2_x,
	input  logic signed [COORD_W-1:0] p2_y,
	input  logic signed [COORD_W-1:0] p3_x,
	input  logic signed [COORD_W-1:0] p3_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [OUT_W-1:0]   curve_x,
	output logic signed [OUT_W-1:0]   curve_y,
	output logic [IDX_W-1:0]          step_index,
	output logic                      last
);

	bcpg_cmd_t  cmd;
	bcpg_stat_t stat;

	// The controller only sequences; all arithmetic lives in the datapath.
	bcpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bcpg_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.steps      (steps),
		.p0_x       (p0_x), .p0_y (p0_y),
		.p1_x       (p1_x), .p1_y (p1_y),
		.p2_x       (p2_x), .p2_y (p2_y),
		.p3_x       (p3_x), .p3_y (p3_y),
		.curve_x    (curve_x),
		.curve_y    (curve_y),
		.step_index (step_index),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

`ifndef NO_ASSERTIONS
	// An accepted item with a nonzero step count keeps the block busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (steps != '0) |=> !in_ready)
		else $error("input taken again right after a nonzero item");

	// While a point other than the last is pending, the run is not finished.
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("block idle before the last point of a run");
`endif

endmodule

// ===== hdl/bcpg_ctrl.sv =====
// Controller state machine for the Bezier curve point generator.
// Sequences weights, multiply-accumulate, division and emit; uses bcpg_pkg.
module bcpg_ctrl import bcpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bcpg_stat_t stat,
	output bcpg_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE, WGT1, WGT2, MAC, DIVI, DIV, EMIT
	} state_t;

	state_t            state_q;
	logic [1:0]        k_q;
	logic [DCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid && !stat.n_zero) state_q <= WGT1;
				end
				WGT1: state_q <= WGT2;
				WGT2: begin
					state_q <= MAC;
					k_q     <= '0;
				end
				MAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'(NPTS - 1)) state_q <= DIVI;
				end
				DIVI: begin
					state_q <= DIV;
					cnt_q   <= '0;
				end
				DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIV_BITS - 1)) state_q <= EMIT;
				end
				EMIT: begin
					if (stat.out_free) state_q <= stat.last_pt ? IDLE : WGT1;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == IDLE) && in_valid;
		cmd.wgt1     = (state_q == WGT1);
		cmd.wgt2     = (state_q == WGT2);
		cmd.mac      = (state_q == MAC);
		cmd.mac_k    = k_q;
		cmd.div_init = (state_q == DIVI);
		cmd.div_step = (state_q == DIV);
		cmd.emit     = (state_q == EMIT) && stat.out_free;
	end

endmodule

// ===== hdl/bcpg_datapath.sv =====
// Datapath for the Bezier curve point generator: weights, accumulators,
// two restoring dividers and the output register; uses bcpg_pkg.
module bcpg_datapath import bcpg_pkg::*; #(
	parameter int MAX_STEPS = 63
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bcpg_cmd_t                 cmd,
	output bcpg_stat_t                stat,
	input  logic                      mode,
	input  logic [IDX_W-1:0]          steps,
	input  logic signed [COORD_W-1:0] p0_x, p0_y, p1_x, p1_y,
	input  logic signed [COORD_W-1:0] p2_x, p2_y, p3_x, p3_y,
	output logic signed [OUT_W-1:0]   curve_x,
	output logic signed [OUT_W-1:0]   curve_y,
	output logic [IDX_W-1:0]          step_index,
	output logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready
);

	localparam int V_W   = ACC_W + 10;
	localparam int REM_W = DEN_W + 1;

	logic                      cubic_q;
	logic [IDX_W-1:0]          n_q, i_q;
	logic signed [COORD_W-1:0] px_q [NPTS];
	logic signed [COORD_W-1:0] py_q [NPTS];
	logic [11:0]               uu_q, ui_q, ii_q, nn_q;
	logic [WGT_W-1:0]          w_q [NPTS];
	logic [DEN_W-1:0]          den_q;
	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
	logic [REM_W-1:0]          rem_x_q, rem_y_q;
	logic [DIV_BITS-1:0]       quo_x_q, quo_y_q;
	logic                      neg_x_q, neg_y_q;

	logic [IDX_W-1:0]          n_eff, u;
	logic signed [WGT_W:0]     wk;
	logic signed [ACC_W-1:0]   prod_x, prod_y;
	logic signed [V_W-1:0]     v_x, v_y, a_x, a_y;
	logic [REM_W:0]            d2, t_x, t_y;

	assign n_eff = (steps > IDX_W'(MAX_STEPS)) ? IDX_W'(MAX_STEPS) : steps;
	assign u     = n_q - i_q;
	assign wk    = $signed({1'b0, w_q[cmd.mac_k]});
	assign prod_x = ACC_W'(wk * px_q[cmd.mac_k]);
	assign prod_y = ACC_W'(wk * py_q[cmd.mac_k]);

	// Rounded value is floor((512*num + D) / 2D); negative dividends use
	// floor(v/d) = ~floor(~v/d).
	assign v_x = (V_W'(acc_x_q) <<< 9) + $signed(V_W'(den_q));
	assign v_y = (V_W'(acc_y_q) <<< 9) + $signed(V_W'(den_q));
	assign a_x = v_x[V_W-1] ? ~v_x : v_x;
	assign a_y = v_y[V_W-1] ? ~v_y : v_y;
	assign d2  = {1'b0, den_q, 1'b0};
	assign t_x = {rem_x_q, quo_x_q[DIV_BITS-1]};
	assign t_y = {rem_y_q, quo_y_q[DIV_BITS-1]};

	assign stat.n_zero   = (n_eff == '0);
	assign stat.last_pt  = (i_q == n_q);
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cubic_q <= mode;
			n_q     <= n_eff;
			i_q     <= '0;
			px_q[0] <= p0_x; px_q[1] <= p1_x; px_q[2] <= p2_x; px_q[3] <= p3_x;
			py_q[0] <= p0_y; py_q[1] <= p1_y; py_q[2] <= p2_y; py_q[3] <= p3_y;
		end
		if (cmd.wgt1) begin
			uu_q <= 12'(u * u);
			ui_q <= 12'(u * i_q);
			ii_q <= 12'(i_q * i_q);
			nn_q <= 12'(n_q * n_q);
		end
		if (cmd.wgt2) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			if (cubic_q) begin
				w_q[0] <= WGT_W'(uu_q * u);
				w_q[1] <= WGT_W'(3 * (uu_q * i_q));
				w_q[2] <= WGT_W'(3 * (ui_q * i_q));
				w_q[3] <= WGT_W'(ii_q * i_q);
				den_q  <= DEN_W'(nn_q * n_q);
			end else begin
				w_q[0] <= WGT_W'(uu_q);
				w_q[1] <= WGT_W'({ui_q, 1'b0});
				w_q[2] <= WGT_W'(ii_q);
				w_q[3] <= '0;
				den_q  <= DEN_W'(nn_q);
			end
		end
		if (cmd.mac) begin
			acc_x_q <= acc_x_q + prod_x;
			acc_y_q <= acc_y_q + prod_y;
		end
		if (cmd.div_init) begin
			neg_x_q <= v_x[V_W-1];
			neg_y_q <= v_y[V_W-1];
			rem_x_q <= a_x[DIV_BITS +: REM_W];
			rem_y_q <= a_y[DIV_BITS +: REM_W];
			quo_x_q <= a_x[DIV_BITS-1:0];
			quo_y_q <= a_y[DIV_BITS-1:0];
		end
		if (cmd.div_step) begin
			if (t_x >= d2) begin
				rem_x_q <= REM_W'(t_x - d2);
				quo_x_q <= {quo_x_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_x_q <= t_x[REM_W-1:0];
				quo_x_q <= {quo_x_q[DIV_BITS-2:0], 1'b0};
			end
			if (t_y >= d2) begin
				rem_y_q <= REM_W'(t_y - d2);
				quo_y_q <= {quo_y_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_y_q <= t_y[REM_W-1:0];
				quo_y_q <= {quo_y_q[DIV_BITS-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			curve_x    <= neg_x_q ? ~quo_x_q : quo_x_q;
			curve_y    <= neg_y_q ? ~quo_y_q : quo_y_q;
			step_index <= i_q;
			last       <= (i_q == n_q);
			i_q        <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// ===== test/bezier_curve_point_generator_tb.sv =====
// Self-checking testbench for the Bezier curve point generator.
// Drives curve requests, predicts every curve point, compares; uses bcpg_pkg.
`timescale 1ns / 1ps

module bezier_curve_point_generator_tb;
	import bcpg_pkg::*;

	// One curve request as it crosses the input channel.
	typedef struct {
		logic                      mode;
		logic [IDX_W-1:0]          steps;
		logic signed [COORD_W-1:0] px [NPTS];
		logic signed [COORD_W-1:0] py [NPTS];
	} curve_req_t;

	// One curve point as it leaves the block.
	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [IDX_W-1:0]        idx;
		logic                    last;
	} curve_pt_t;

	localparam int LIMIT_CYCLES = 1500000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      mode;
	logic [IDX_W-1:0]          steps;
	logic signed [COORD_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [OUT_W-1:0]   curve_x;
	logic signed [OUT_W-1:0]   curve_y;
	logic [IDX_W-1:0]          step_index;
	logic                      last;

	curve_req_t pending_reqs[$];
	curve_pt_t  expected_pts[$];
	int         mismatches = 0;
	int         cycle_count = 0;

	// The receiver holds off while this is set; the sender stops while
	// sender_pause is set. Both are steered by the stimulus process.
	bit         rx_hold = 0;
	bit         sender_pause = 0;
	bit         calm = 0;

	bezier_curve_point_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .steps(steps),
		.p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
		.p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.curve_x(curve_x), .curve_y(curve_y),
		.step_index(step_index), .last(last)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Rounds num/den to 8 fraction bits, nearest with ties toward plus
	// infinity. The division is floored, so negative remainders step down.
	function automatic logic signed [OUT_W-1:0] round_to_fix8(longint num, longint den);
		longint v, d2, q;
		v  = num * 512 + den;
		d2 = den * 2;
		q  = v / d2;
		if (v < 0 && (v % d2) != 0)
			q = q - 1;
		return q[OUT_W-1:0];
	endfunction

	// Expands one request into its curve points, appended to expected_pts.
	task automatic predict_curve(input curve_req_t r);
		longint n, u, den, nx, ny;
		longint w [NPTS];
		curve_pt_t pt;
		n = longint'(r.steps);
		if (n > 63)
			n = 63;
		if (n == 0)
			return;
		for (longint i = 0; i <= n; i++) begin
			u = n - i;
			if (r.mode) begin
				w[0] = u * u * u;
				w[1] = 3 * u * u * i;
				w[2] = 3 * u * i * i;
				w[3] = i * i * i;
				den = n * n * n;
			end else begin
				w[0] = u * u;
				w[1] = 2 * u * i;
				w[2] = i * i;
				w[3] = 0;
				den = n * n;
			end
			nx = 0;
			ny = 0;
			for (int k = 0; k < NPTS; k++) begin
				nx += w[k] * longint'(r.px[k]);
				ny += w[k] * longint'(r.py[k]);
			end
			pt.x    = round_to_fix8(nx, den);
			pt.y    = round_to_fix8(ny, den);
			pt.idx  = i[IDX_W-1:0];
			pt.last = (i == n);
			expected_pts.push_back(pt);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	function automatic curve_req_t random_req(input bit small_steps);
		curve_req_t r;
		r.mode  = 1'($urandom_range(0, 1));
		r.steps = small_steps ? IDX_W'($urandom_range(1, 6)) : IDX_W'($urandom_range(0, 63));
		for (int k = 0; k < NPTS; k++) begin
			// Mostly full range, sometimes the extremes.
			case ($urandom_range(0, 5))
				0: r.px[k] = 16'sh7fff;
				1: r.px[k] = 16'sh8000;
				default: r.px[k] = COORD_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: r.py[k] = 16'sh8000;
				1: r.py[k] = 16'sh7fff;
				default: r.py[k] = COORD_W'($urandom);
			endcase
		end
		return r;
	endfunction

	function automatic curve_req_t const_req(input logic m, input logic [IDX_W-1:0] n,
	                                         input logic signed [COORD_W-1:0] vx,
	                                         input logic signed [COORD_W-1:0] vy);
		curve_req_t r;
		r.mode  = m;
		r.steps = n;
		for (int k = 0; k < NPTS; k++) begin
			r.px[k] = vx;
			r.py[k] = vy;
		end
		return r;
	endfunction

	// Driver: the predictor runs at acceptance, so expectations exist in
	// item order before the block can produce the first point.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode     <= 1'b0;
			steps    <= '0;
			{p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} <= '0;
		end else begin
			automatic bit fire = in_valid && in_ready;
			automatic curve_req_t r;
			if (fire)
				predict_curve(pending_reqs.pop_front());
			if (!in_valid || fire) begin
				if (pending_reqs.size() > 0 && !sender_pause &&
				    (calm || $urandom_range(0, 99) >= 24)) begin
					r = pending_reqs[0];
					in_valid <= 1'b1;
					mode     <= r.mode;
					steps    <= r.steps;
					p0_x <= r.px[0]; p0_y <= r.py[0];
					p1_x <= r.px[1]; p1_y <= r.py[1];
					p2_x <= r.px[2]; p2_y <= r.py[2];
					p3_x <= r.px[3]; p3_y <= r.py[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted point against the oldest expectation
	// and chooses the next cycle's ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				if (expected_pts.size() == 0) begin
					report_mismatch("unexpected point, index", longint'(step_index),
					                longint'(-1));
				end else begin
					automatic curve_pt_t e = expected_pts.pop_front();
					if (curve_x !== e.x)
						report_mismatch("curve_x", longint'(curve_x), longint'(e.x));
					if (curve_y !== e.y)
						report_mismatch("curve_y", longint'(curve_y), longint'(e.y));
					if (step_index !== e.idx)
						report_mismatch("step_index", longint'(step_index),
						                longint'(e.idx));
					if (last !== e.last)
						report_mismatch("last", longint'(last), longint'(e.last));
				end
			end
			out_ready <= !rx_hold && (calm || $urandom_range(0, 99) >= 24);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_pts.size() > 0)
			@(posedge clk);
	endtask

	// Stimulus: directed corners, then random requests with pressure phases.
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes, both degrees, zero steps (no points), largest N, a quadratic
		// item with wild p3 that must be ignored, alternating extremes, random items.
		pending_reqs.push_back(const_req(1'b0, 6'd1, 16'sh7fff, 16'sh8000));
		pending_reqs.push_back(const_req(1'b1, 6'd1, 16'sh8000, 16'sh7fff));
		pending_reqs.push_back(const_req(1'b0, 6'd0, 16'sh1234, 16'sh4321));
		pending_reqs.push_back(const_req(1'b1, 6'd0, 16'sh0001, 16'shffff));
		pending_reqs.push_back(const_req(1'b1, 6'd63, 16'sh7fff, 16'sh8000));
		pending_reqs.push_back(const_req(1'b0, 6'd63, 16'sh8000, 16'sh7fff));
		begin
			automatic curve_req_t r = const_req(1'b0, 6'd3, 16'sh0000, 16'sh0000);
			r.px[3] = 16'sh7fff;
			r.py[3] = 16'sh8000;
			r.px[1] = 16'sh7fff;
			r.py[1] = 16'sh8000;
			pending_reqs.push_back(r);
			r.px = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
			r.py = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
			r.mode = 1'b1;
			r.steps = 6'd7;
			pending_reqs.push_back(r);
			r.steps = 6'd2;
			pending_reqs.push_back(r);
			r.mode = 1'b0;
			pending_reqs.push_back(r);
		end
		for (int j = 0; j < 10; j++)
			pending_reqs.push_back(random_req(1'b0));
		wait_drained();

		// Long receiver stall while the sender keeps offering items.
		rx_hold = 1;
		for (int j = 0; j < 20; j++)
			pending_reqs.push_back(random_req(1'b1));
		repeat (600) @(posedge clk);
		rx_hold = 0;
		wait_drained();

		// Sender pause while new requests queue up, then resume.
		sender_pause = 1;
		for (int j = 0; j < 10; j++)
			pending_reqs.push_back(random_req(1'b1));
		repeat (50) @(posedge clk);
		sender_pause = 0;
		wait_drained();

		// Stretch with no idling on either side.
		calm = 1;
		for (int j = 0; j < 30; j++)
			pending_reqs.push_back(random_req($urandom_range(0, 3) != 0));
		wait_drained();
		calm = 0;

		// Bulk random traffic, mostly short curves.
		for (int j = 0; j < 100; j++)
			pending_reqs.push_back(random_req($urandom_range(0, 4) != 0));
		wait_drained();

		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_pts.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
